// File: rtl/core/rcfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcfe_pkg;

  localparam int PULSE_W    = 12;
  localparam int TIME_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Config register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIDPOINT     = 2'd0,
    CFG_SPEED_OFFSET = 2'd1,
    CFG_LONG_PRESS   = 2'd2,
    CFG_HEADER       = 2'd3
  } cfg_index_t;

  // Byte positions within a frame, in transmit order
  typedef enum logic [2:0] {
    SLOT_HEADER  = 3'd0,
    SLOT_SW_TWO  = 3'd1,
    SLOT_SW_ONE  = 3'd2,
    SLOT_CALIB   = 3'd3,
    SLOT_LAND    = 3'd4,
    SLOT_SPEED_A = 3'd5,
    SLOT_SPEED_B = 3'd6
  } slot_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic              sw_two;
    logic              sw_one;
    logic              calib;
    logic              land;
    logic [BYTE_W-1:0] speed_a;
    logic [BYTE_W-1:0] speed_b;
  } frame_t;

endpackage

`default_nettype wire

// File: rtl/core/rc_command_frame_encoder.sv
// Channel   Direction  Handshake          Payload
// --------  ---------  -----------------  ---------------------------------------------
// config    in         cfg_we             cfg_index, cfg_data
// tick      in         push / full        stick_a/b, switch_one/two, enable, button, now_ms
// frame     out        empty / pop        frame_byte, frame_last
//
// Each tick yields a 7-byte frame, one byte per cycle while pop is held; the byte serializer
// in the back end takes the next frame only as the last byte of the current one is popped.
// The first byte reaches the ports after the two front stages, the queue and the serializer.
// Ticks are taken every cycle until the queue backs up.
// Reset (rst, synchronous) restores register defaults, clears button state and flags,
// and drops anything in flight. A stalled pop holds the current byte; full rises once
// the front stages and the QUEUE_DEPTH-entry frame queue are all occupied.
`timescale 1ns / 1ps
`default_nettype none

module rc_command_frame_encoder import rcfe_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [PULSE_W-1:0]    stick_a_pulse,
  input  wire logic [PULSE_W-1:0]    stick_b_pulse,
  input  wire logic [PULSE_W-1:0]    switch_one_pulse,
  input  wire logic [PULSE_W-1:0]    switch_two_pulse,
  input  wire logic [PULSE_W-1:0]    enable_pulse,
  input  wire logic [PULSE_W-1:0]    button_pulse,
  input  wire logic [TIME_W-1:0]     now_ms,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [BYTE_W-1:0]          frame_byte,
  output logic                       frame_last
);

  logic   fr_valid, fr_ready;
  frame_t fr_frame;
  logic   bk_valid, bk_ready;
  frame_t bk_frame;

  rcfe_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .stick_a_pulse    (stick_a_pulse),
    .stick_b_pulse    (stick_b_pulse),
    .switch_one_pulse (switch_one_pulse),
    .switch_two_pulse (switch_two_pulse),
    .enable_pulse     (enable_pulse),
    .button_pulse     (button_pulse),
    .now_ms           (now_ms),
    .out_valid        (fr_valid),
    .out_frame        (fr_frame),
    .out_ready        (fr_ready)
  );

  rcfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_frame),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_data  (bk_frame)
  );

  rcfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (bk_valid),
    .in_ready   (bk_ready),
    .in_frame   (bk_frame),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
  );

endmodule

`default_nettype wire

// File: rtl/core/rcfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfe_front import rcfe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [PULSE_W-1:0]    stick_a_pulse,
  input  wire logic [PULSE_W-1:0]    stick_b_pulse,
  input  wire logic [PULSE_W-1:0]    switch_one_pulse,
  input  wire logic [PULSE_W-1:0]    switch_two_pulse,
  input  wire logic [PULSE_W-1:0]    enable_pulse,
  input  wire logic [PULSE_W-1:0]    button_pulse,
  input  wire logic [TIME_W-1:0]     now_ms,
  output logic                       out_valid,
  output frame_t                     out_frame,
  input  wire logic                  out_ready
);

  localparam logic [PULSE_W-1:0] DEADBAND = PULSE_W'(50);
  // ceil(2^16 / 17); exact quotient for every 12-bit magnitude
  localparam int                  RECIP_SHIFT = 16;
  localparam logic [PULSE_W-1:0]  RECIP       = PULSE_W'(3856);
  localparam int                  PROD_W      = 2 * PULSE_W;

  typedef struct packed {
    logic               neg;
    logic               active;
    logic [PULSE_W-1:0] mag;
  } stick_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic              sw_two;
    logic              sw_one;
    logic              calib;
    logic              land;
    stick_t            a;
    stick_t            b;
  } stage_t;

  function automatic stick_t classify(input logic [PULSE_W-1:0] pulse,
                                      input logic [PULSE_W-1:0] mid,
                                      input logic               enabled);
    stick_t s;
    s.neg    = pulse < mid;
    s.mag    = s.neg ? (mid - pulse) : (pulse - mid);
    s.active = enabled && (s.mag > DEADBAND);
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] speed_byte(input stick_t s,
                                                   input logic [BYTE_W-1:0] offset);
    logic [PROD_W-1:0] prod;
    logic [BYTE_W-1:0] q;
    prod = PROD_W'(s.mag) * PROD_W'(RECIP);
    q    = prod[RECIP_SHIFT +: BYTE_W];
    if (!s.active) return offset;
    return s.neg ? (offset - q) : (offset + q);
  endfunction

  logic [PULSE_W-1:0] pulse_midpoint;
  logic [BYTE_W-1:0]  speed_offset;
  logic [HOLD_W-1:0]  long_press_ms;
  logic [BYTE_W-1:0]  header_byte;

  logic              button_was_high;
  logic [TIME_W-1:0] press_start_ms;
  logic              calib_flag;
  logic              land_flag;

  logic   s1_valid;
  stage_t s1;
  logic   s2_valid;
  frame_t s2;

  logic              s1_ready, s2_ready, accept;
  logic              btn_above, press, release_evt, long_hold;
  logic              calib_next, land_next;
  logic [TIME_W-1:0] elapsed;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign full     = !s1_ready;
  assign accept   = push && !full;

  always_comb begin
    btn_above   = button_pulse > pulse_midpoint;
    press       = btn_above && !button_was_high;
    release_evt = (button_pulse < pulse_midpoint) && button_was_high;
    elapsed     = now_ms - press_start_ms;
    long_hold   = elapsed > TIME_W'(long_press_ms);
    calib_next  = calib_flag ^ (release_evt && long_hold);
    land_next   = land_flag ^ (release_evt && !long_hold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_midpoint <= PULSE_W'(1500);
      speed_offset   <= BYTE_W'(128);
      long_press_ms  <= HOLD_W'(2000);
      header_byte    <= BYTE_W'(170);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIDPOINT:     pulse_midpoint <= cfg_data[PULSE_W-1:0];
        CFG_SPEED_OFFSET: speed_offset   <= cfg_data[BYTE_W-1:0];
        CFG_LONG_PRESS:   long_press_ms  <= cfg_data[HOLD_W-1:0];
        CFG_HEADER:       header_byte    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Button tracking is updated at accept time so back-to-back ticks see it
  always_ff @(posedge clk) begin
    if (rst) begin
      button_was_high <= 1'b0;
      press_start_ms  <= '0;
      calib_flag      <= 1'b0;
      land_flag       <= 1'b0;
    end else if (accept) begin
      button_was_high <= btn_above;
      calib_flag      <= calib_next;
      land_flag       <= land_next;
      if (press) press_start_ms <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= accept;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.header <= header_byte;
      s1.sw_two <= switch_two_pulse > pulse_midpoint;
      s1.sw_one <= switch_one_pulse > pulse_midpoint;
      s1.calib  <= calib_next;
      s1.land   <= land_next;
      s1.a      <= classify(stick_a_pulse, pulse_midpoint, enable_pulse > pulse_midpoint);
      s1.b      <= classify(stick_b_pulse, pulse_midpoint, enable_pulse > pulse_midpoint);
    end
    if (s1_valid && s2_ready) begin
      s2.header  <= s1.header;
      s2.sw_two  <= s1.sw_two;
      s2.sw_one  <= s1.sw_one;
      s2.calib   <= s1.calib;
      s2.land    <= s1.land;
      s2.speed_a <= speed_byte(s1.a, speed_offset);
      s2.speed_b <= speed_byte(s1.b, speed_offset);
    end
  end

  assign out_valid = s2_valid;
  assign out_frame = s2;

endmodule

`default_nettype wire

// File: rtl/core/rcfe_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfe_fifo import rcfe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire frame_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output frame_t      out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               wr_en, rd_en;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= in_data;
  end

endmodule

`default_nettype wire

// File: rtl/core/rcfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfe_back import rcfe_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire frame_t       in_frame,
  output logic              empty,
  input  wire logic         pop,
  output logic [BYTE_W-1:0] frame_byte,
  output logic              frame_last
);

  logic   busy;
  slot_t  slot;
  frame_t frame;
  logic   done;

  assign frame_last = slot == SLOT_SPEED_B;
  assign empty      = !busy;
  assign done       = busy && pop && frame_last;
  // next frame loads on the same edge the last byte leaves
  assign in_ready   = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_HEADER;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      slot <= SLOT_HEADER;
    end else if (done) begin
      busy <= 1'b0;
      slot <= SLOT_HEADER;
    end else if (busy && pop) begin
      slot <= slot_t'(slot + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) frame <= in_frame;
  end

  always_comb begin
    unique case (slot)
      SLOT_HEADER:  frame_byte = frame.header;
      SLOT_SW_TWO:  frame_byte = BYTE_W'(frame.sw_two);
      SLOT_SW_ONE:  frame_byte = BYTE_W'(frame.sw_one);
      SLOT_CALIB:   frame_byte = BYTE_W'(frame.calib);
      SLOT_LAND:    frame_byte = BYTE_W'(frame.land);
      SLOT_SPEED_A: frame_byte = frame.speed_a;
      SLOT_SPEED_B: frame_byte = frame.speed_b;
      default:      frame_byte = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rcfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfe_checker import rcfe_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [BYTE_W-1:0] frame_byte,
  input wire logic              frame_last
);

  // nothing in flight right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("output not empty or input full after reset");

  // a frame always restarts at its header, never two last bytes in a row
  a_last_then_header: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && frame_last) |=> (empty || !frame_last))
    else $error("frame_last shown on first byte of next frame");

  // an accepted tick reaches the output within the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> ##4 !empty)
    else $error("accepted tick did not reach the output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(frame_last)))
    else $error("waiting result changed before pop");

endmodule

bind rc_command_frame_encoder rcfe_checker u_rcfe_checker (.*);

`default_nettype wire
